// ===== src/md5bc_pkg.sv =====
// Package for the MD5 block compression engine: microcode types, program ROM,
// round constants and index helpers. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package md5bc_pkg;

    // Sequencer step addresses.
    localparam logic [2:0] STEP_COLLECT = 3'd0;
    localparam logic [2:0] STEP_INIT    = 3'd1;
    localparam logic [2:0] STEP_ROUND   = 3'd2;
    localparam logic [2:0] STEP_ADD     = 3'd3;
    localparam logic [2:0] STEP_EMIT    = 3'd4;
    localparam logic [2:0] STEP_CLEAR   = 3'd5;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [3:0] LAST_SLOT  = 4'd15;
    localparam logic [1:0] LAST_DIGEST = 2'd3;

    // Standard initial chaining words.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Branch conditions: when the condition holds the sequencer goes to the
    // target, otherwise to the following step.
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_WAIT_BLOCK,
        BR_ROUNDS_LEFT,
        BR_NOT_FINAL,
        BR_WAIT_EMIT
    } branch_t;

    typedef struct packed {
        logic       in_ready;
        logic       init;
        logic       round;
        logic       add;
        logic       emit;
        logic       clear;
        branch_t    br;
        logic [2:0] target;
    } ctrl_word_t;

    // Per-round additive constants.
    localparam logic [31:0] SINE_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Microcode program, one control word per step.
    function automatic ctrl_word_t prog_rom(input logic [2:0] pc);
        ctrl_word_t cw;
        cw = '{in_ready: 1'b0, init: 1'b0, round: 1'b0, add: 1'b0, emit: 1'b0,
               clear: 1'b0, br: BR_ALWAYS, target: STEP_COLLECT};
        case (pc)
            STEP_COLLECT: begin
                cw.in_ready = 1'b1;
                cw.br       = BR_WAIT_BLOCK;
                cw.target   = STEP_COLLECT;
            end
            STEP_INIT: begin
                cw.init = 1'b1;
                cw.br   = BR_NEXT;
            end
            STEP_ROUND: begin
                cw.round  = 1'b1;
                cw.br     = BR_ROUNDS_LEFT;
                cw.target = STEP_ROUND;
            end
            STEP_ADD: begin
                cw.add    = 1'b1;
                cw.br     = BR_NOT_FINAL;
                cw.target = STEP_COLLECT;
            end
            STEP_EMIT: begin
                cw.emit   = 1'b1;
                cw.br     = BR_WAIT_EMIT;
                cw.target = STEP_EMIT;
            end
            STEP_CLEAR: begin
                cw.clear  = 1'b1;
                cw.br     = BR_ALWAYS;
                cw.target = STEP_COLLECT;
            end
            default: begin
                cw.br     = BR_ALWAYS;
                cw.target = STEP_COLLECT;
            end
        endcase
        return cw;
    endfunction

    // Message word index used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = 4'((lo << 2) + lo + 4'd1);
            2'd2:    idx = 4'((lo << 1) + lo + 4'd5);
            default: idx = 4'((lo << 3) - lo);
        endcase
        return idx;
    endfunction

    // Left-rotate amount of a round, by group and position in the group.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] amt;
        case ({r[5:4], r[1:0]})
            4'h0: amt = 5'd7;
            4'h1: amt = 5'd12;
            4'h2: amt = 5'd17;
            4'h3: amt = 5'd22;
            4'h4: amt = 5'd5;
            4'h5: amt = 5'd9;
            4'h6: amt = 5'd14;
            4'h7: amt = 5'd20;
            4'h8: amt = 5'd4;
            4'h9: amt = 5'd11;
            4'ha: amt = 5'd16;
            4'hb: amt = 5'd23;
            4'hc: amt = 5'd6;
            4'hd: amt = 5'd10;
            4'he: amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

endpackage

`default_nettype wire

// ===== src/md5_block_compress.sv =====
// MD5 compression engine: microcoded sequencer, block buffer and round datapath.
// Depends on md5bc_pkg for the program ROM, round constants and index helpers.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// input     s_valid/s_ready    s_message_word[31:0], s_final_block
// digest    m_valid/m_ready    m_digest_word[31:0], m_digest_index[1:0], m_digest_last
//
// Sixteen words are taken one per cycle while s_valid is high; the block is then
// compressed by one setup step, 64 rounds on the single round unit and one add
// step, and no new word is taken until that is done.
// A final block adds four digest words, one per cycle while m_ready is high,
// and one step that clears the chaining words.
// Reset is synchronous and active low; the engine starts ready for words.
// No input word is taken while a block is compressed or a digest is out.

module md5_block_compress (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_message_word,
    input  wire         s_final_block,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_digest_index,
    output logic        m_digest_last
);
    import md5bc_pkg::*;

    logic [2:0]  pc_reg, pc_next;
    ctrl_word_t  ctrl;
    logic        take_branch;

    logic [3:0]  word_count_reg;
    logic [5:0]  round_count_reg;
    logic        active_reg;
    logic        final_reg;
    logic [1:0]  out_idx_reg;

    logic [31:0] chain_reg [4];
    logic [31:0] work_reg  [4];

    logic [31:0] buf_mem [16];
    logic [3:0]  rd_addr;
    logic [31:0] msg_rd_reg;

    logic        in_acc, out_acc, block_done;
    logic [31:0] fa, fb, fc, fd;
    logic [31:0] f_val, round_sum, rot_val;
    logic [4:0]  amt;

    assign in_acc     = s_valid && s_ready;
    assign out_acc    = m_valid && m_ready;
    assign block_done = in_acc && (word_count_reg == LAST_SLOT);

    // Fetch the control word of the current step.
    assign ctrl    = prog_rom(pc_reg);
    assign s_ready = ctrl.in_ready;

    // Branch evaluation and next step address.
    always_comb begin
        case (ctrl.br)
            BR_NEXT:        take_branch = 1'b0;
            BR_ALWAYS:      take_branch = 1'b1;
            BR_WAIT_BLOCK:  take_branch = !block_done;
            BR_ROUNDS_LEFT: take_branch = (round_count_reg != LAST_ROUND);
            BR_NOT_FINAL:   take_branch = !final_reg;
            BR_WAIT_EMIT:   take_branch = !(out_acc && (out_idx_reg == LAST_DIGEST));
            default:        take_branch = 1'b1;
        endcase
        pc_next = take_branch ? ctrl.target : pc_reg + 3'd1;
    end

    // Round function on the working words.
    assign fa  = work_reg[0];
    assign fb  = work_reg[1];
    assign fc  = work_reg[2];
    assign fd  = work_reg[3];
    assign amt = rot_amount(round_count_reg);

    always_comb begin
        case (round_count_reg[5:4])
            2'd0:    f_val = (fb & fc) | (~fb & fd);
            2'd1:    f_val = (fd & fb) | (~fd & fc);
            2'd2:    f_val = fb ^ fc ^ fd;
            default: f_val = fc ^ (fb | ~fd);
        endcase
        round_sum = f_val + fa + SINE_TABLE[round_count_reg] + msg_rd_reg;
        rot_val   = (round_sum << amt) | (round_sum >> (6'd32 - {1'b0, amt}));
    end

    // Buffer read address: the setup step fetches round 0, each round the next.
    assign rd_addr = ctrl.init ? msg_index(6'd0) : msg_index(round_count_reg + 6'd1);

    // Block buffer memory with registered read.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            buf_mem[word_count_reg] <= s_message_word;
        end
        msg_rd_reg <= buf_mem[rd_addr];
    end

    // Sequencer, counters and chaining state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= STEP_COLLECT;
            word_count_reg  <= '0;
            round_count_reg <= '0;
            active_reg      <= 1'b0;
            final_reg       <= 1'b0;
            out_idx_reg     <= '0;
            for (int i = 0; i < 4; i++) begin
                chain_reg[i] <= '0;
                work_reg[i]  <= '0;
            end
        end else begin
            pc_reg <= pc_next;
            if (in_acc) begin
                word_count_reg <= word_count_reg + 4'd1;
                if (word_count_reg == LAST_SLOT) begin
                    final_reg <= s_final_block;
                end
            end
            if (ctrl.init) begin
                round_count_reg <= '0;
                active_reg      <= 1'b1;
                if (!active_reg) begin
                    chain_reg[0] <= IV_A;
                    chain_reg[1] <= IV_B;
                    chain_reg[2] <= IV_C;
                    chain_reg[3] <= IV_D;
                    work_reg[0]  <= IV_A;
                    work_reg[1]  <= IV_B;
                    work_reg[2]  <= IV_C;
                    work_reg[3]  <= IV_D;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        work_reg[i] <= chain_reg[i];
                    end
                end
            end
            if (ctrl.round) begin
                round_count_reg <= round_count_reg + 6'd1;
                work_reg[0]     <= fd;
                work_reg[1]     <= fb + rot_val;
                work_reg[2]     <= fb;
                work_reg[3]     <= fc;
            end
            if (ctrl.add) begin
                for (int i = 0; i < 4; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (out_acc) begin
                out_idx_reg <= out_idx_reg + 2'd1;
            end
            if (ctrl.clear) begin
                active_reg <= 1'b0;
                for (int i = 0; i < 4; i++) begin
                    chain_reg[i] <= '0;
                end
            end
        end
    end

    // Digest words come straight from the chaining registers.
    assign m_valid        = ctrl.emit;
    assign m_digest_word  = chain_reg[out_idx_reg];
    assign m_digest_index = out_idx_reg;
    assign m_digest_last  = (out_idx_reg == LAST_DIGEST);

    // The engine never takes a word while a digest is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while digest is offered");

    // The sixteenth word starts the compression in the next cycle.
    a_block_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        block_done |=> (pc_reg == STEP_INIT))
        else $error("full block did not start compression");

    // Rounds only run on a message that has been set up.
    a_round_active: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.round |-> active_reg)
        else $error("round step without an active message");

    // The last digest word leads to clearing of the chaining words.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_digest_last) |=> (pc_reg == STEP_CLEAR))
        else $error("digest end did not clear chaining state");

endmodule

`default_nettype wire
